[design/mqm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-queue mailbox package
// Sizes, command and status codes, item types and ring-pointer helpers.
// ----------------------------------------------------------------------------
package mqm_pkg;

    localparam int QUEUES = 4;
    localparam int DEPTH  = 15;
    localparam int TASKS  = 8;

    localparam int RING    = DEPTH + 1;
    localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int PTR_W   = $clog2(RING);
    localparam int CNT_W   = $clog2(RING + 1);
    localparam int SLOTS   = QUEUES * RING;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [7:0] TASK_ALL = 8'(8'hFF >> (8 - TASKS));

    localparam logic [2:0] CMD_INIT        = 3'd0;
    localparam logic [2:0] CMD_SEND        = 3'd1;
    localparam logic [2:0] CMD_RECEIVE     = 3'd2;
    localparam logic [2:0] CMD_RESUME_SEND = 3'd3;
    localparam logic [2:0] CMD_RESUME_RECV = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_BLOCKED = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  queue_id;
        logic [2:0]  task_id;
        logic [15:0] send_value;
        logic        may_wait;
        logic [4:0]  queue_length;
        logic [7:0]  access_mask;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] read_data;
        logic [7:0]  wake_mask;
    } rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       allowed;
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [15:0]      waiting;
    } ctrl_t;

    typedef struct packed {
        logic               ctrl_we;
        ctrl_t              ctrl_wdata;
        logic               slot_we;
        logic               slot_re;
        logic [SLOT_AW-1:0] slot_addr;
        logic [15:0]        slot_wdata;
        logic [2:0]         status;
        logic [7:0]         wake;
        logic               recv_ok;
    } exec_t;

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] ptr,
                                                      input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n;
        begin
            n = CNT_W'(ptr) + CNT_W'(1);
            if (n >= count || n >= CNT_W'(RING)) begin
                ring_advance = '0;
            end else begin
                ring_advance = PTR_W'(n);
            end
        end
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_index(input logic [QIDX_W-1:0] q,
                                                      input logic [PTR_W-1:0] ptr);
        begin
            slot_index = SLOT_AW'(SLOT_AW'(q) * SLOT_AW'(RING)) + SLOT_AW'(ptr);
        end
    endfunction

endpackage
`default_nettype wire

[design/multi_queue_mailbox_with_wait_masks_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-queue mailbox with wait masks
// A bank of ring-buffer queues of 16-bit words with access and wait masks.
//
// The input channel (s_valid, s_ready, s_req) takes one command item: init,
// send, receive, resume send or resume receive. The result channel
// (m_valid, m_ready, m_rsp) returns exactly one item per command: a status,
// the word removed by a successful receive and the mask of waiting tasks
// to wake.
// An item is handled in order: the control word of the queue is
// read from the control memory, then it is updated and written back while
// the slot memory is written or read, then the slot word is registered into
// the result. The control read and the slot read are both registered, so
// these steps run one after the other; the block takes no new item until
// the result of the last one is loaded into the output register.
// Reset clears the state machine, the result valid flag and the control
// memory valid bits, so every queue reads as uninitialized; no clearing
// pass is needed. When the receiver stalls, a result waits in the output
// register; the block still accepts and processes the next item and holds
// it until the output register is free.
// ----------------------------------------------------------------------------
module multi_queue_mailbox_with_wait_masks_top
    import mqm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output      logic s_ready,
    input  wire req_t s_req,
    output      logic m_valid,
    input  wire logic m_ready,
    output      rsp_t m_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    req_t        req_reg;
    ctrl_t       ctrl_rd;
    exec_t       ex;
    logic [2:0]  status_reg;
    logic [7:0]  wake_reg;
    logic        recv_ok_reg;
    logic [15:0] slot_rd;
    logic        m_valid_reg, m_valid_next;
    rsp_t        m_rsp_reg;
    logic        accept;
    logic        exec_go;
    logic        out_load;

    assign s_ready  = state_reg == S_IDLE;
    assign accept   = s_valid && s_ready;
    assign exec_go  = state_reg == S_EXEC;
    assign out_load = state_reg == S_RESP && (!m_valid_reg || m_ready);

    mqm_ctrl_store u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s_req.queue_id[QIDX_W-1:0]),
        .rd_data (ctrl_rd),
        .wr_en   (exec_go && ex.ctrl_we),
        .wr_addr (req_reg.queue_id[QIDX_W-1:0]),
        .wr_data (ex.ctrl_wdata)
    );

    mqm_engine u_engine (
        .req  (req_reg),
        .ctrl (ctrl_rd),
        .ex   (ex)
    );

    mqm_slot_store u_slots (
        .aclk    (aclk),
        .rd_en   (exec_go && ex.slot_re),
        .wr_en   (exec_go && ex.slot_we),
        .addr    (ex.slot_addr),
        .wr_data (ex.slot_wdata),
        .rd_data (slot_rd)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req;
        end
        if (exec_go) begin
            status_reg  <= ex.status;
            wake_reg    <= ex.wake;
            recv_ok_reg <= ex.recv_ok;
        end
        if (out_load) begin
            m_rsp_reg.status    <= status_reg;
            m_rsp_reg.read_data <= recv_ok_reg ? slot_rd : 16'd0;
            m_rsp_reg.wake_mask <= wake_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule
`default_nettype wire

[design/mqm_ctrl_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Queue control store
// Per-queue pointers, capacity, access and wait masks in a synchronous
// memory with a registered read; entries never written read as zero.
// ----------------------------------------------------------------------------
module mqm_ctrl_store
    import mqm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [QIDX_W-1:0] rd_addr,
    output      ctrl_t             rd_data,
    input  wire logic              wr_en,
    input  wire logic [QIDX_W-1:0] wr_addr,
    input  wire ctrl_t             wr_data
);

    ctrl_t             mem [QUEUES];
    logic [QUEUES-1:0] valid_reg;
    ctrl_t             rd_word_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule
`default_nettype wire

[design/mqm_slot_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Slot store
// Ring-buffer words of all queues in one synchronous memory with one
// write port and one registered read port that share one address.
// ----------------------------------------------------------------------------
module mqm_slot_store
    import mqm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               rd_en,
    input  wire logic               wr_en,
    input  wire logic [SLOT_AW-1:0] addr,
    input  wire logic [15:0]        wr_data,
    output      logic [15:0]        rd_data
);

    logic [15:0] mem [SLOTS];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[design/mqm_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Command engine
// Decodes one command against the control word of its queue and produces
// the control write-back, the slot access and the result fields.
// ----------------------------------------------------------------------------
module mqm_engine
    import mqm_pkg::*;
(
    input  wire req_t  req,
    input  wire ctrl_t ctrl,
    output      exec_t ex
);

    logic              q_ok;
    logic              task_ok;
    logic [QIDX_W-1:0] q_idx;
    logic [7:0]        access_m;
    logic              init_ok;
    logic              use_ok;
    logic              sending;
    logic              resume;
    logic [15:0]       send_bit;
    logic [15:0]       recv_bit;
    logic [15:0]       wait_cl;
    logic [PTR_W-1:0]  tail_nx;
    logic [PTR_W-1:0]  head_nx;
    logic              can_send;
    logic              can_recv;

    always_comb begin
        q_ok     = {1'b0, req.queue_id} < 4'(QUEUES);
        task_ok  = {1'b0, req.task_id} < 4'(TASKS);
        q_idx    = req.queue_id[QIDX_W-1:0];
        access_m = req.access_mask & TASK_ALL;
        init_ok  = q_ok && req.queue_length != 5'd0 && {1'b0, req.queue_length} <= 6'(DEPTH)
                   && access_m != 8'd0;
        use_ok   = req.command != CMD_INIT && req.command <= CMD_RESUME_RECV && q_ok
                   && task_ok && ctrl.allowed[req.task_id];
        sending  = req.command == CMD_SEND || req.command == CMD_RESUME_SEND;
        resume   = req.command == CMD_RESUME_SEND || req.command == CMD_RESUME_RECV;
        send_bit = 16'd1 << (5'(req.task_id) + 5'd8);
        recv_bit = 16'd1 << req.task_id;
        wait_cl  = resume ? (ctrl.waiting & ~(sending ? send_bit : recv_bit)) : ctrl.waiting;
        tail_nx  = ring_advance(ctrl.tail, ctrl.count);
        head_nx  = ring_advance(ctrl.head, ctrl.count);
        can_send = tail_nx != ctrl.head;
        can_recv = ctrl.head != ctrl.tail;

        ex            = '0;
        ex.ctrl_wdata = ctrl;
        ex.slot_wdata = req.send_value;
        ex.slot_addr  = slot_index(q_idx, sending ? ctrl.tail : ctrl.head);
        ex.status     = ST_INVALID;

        if (req.command == CMD_INIT) begin
            if (init_ok) begin
                ex.ctrl_we            = 1'b1;
                ex.ctrl_wdata.count   = CNT_W'(req.queue_length) + CNT_W'(1);
                ex.ctrl_wdata.allowed = access_m;
                ex.ctrl_wdata.head    = '0;
                ex.ctrl_wdata.tail    = '0;
                ex.ctrl_wdata.waiting = '0;
                ex.status             = ST_OK;
            end
        end else if (use_ok) begin
            ex.ctrl_we            = 1'b1;
            ex.ctrl_wdata.waiting = wait_cl;
            if (sending) begin
                if (can_send) begin
                    ex.slot_we         = 1'b1;
                    ex.ctrl_wdata.tail = tail_nx;
                    ex.status          = ST_OK;
                    ex.wake            = wait_cl[7:0];
                end else if (!resume && req.may_wait) begin
                    ex.ctrl_wdata.waiting = wait_cl | send_bit;
                    ex.status             = ST_BLOCKED;
                end else begin
                    ex.status = ST_FULL;
                end
            end else begin
                if (can_recv) begin
                    ex.slot_re         = 1'b1;
                    ex.recv_ok         = 1'b1;
                    ex.ctrl_wdata.head = head_nx;
                    ex.status          = ST_OK;
                    ex.wake            = wait_cl[15:8];
                end else if (!resume && req.may_wait) begin
                    ex.ctrl_wdata.waiting = wait_cl | recv_bit;
                    ex.status             = ST_BLOCKED;
                end else begin
                    ex.status = ST_EMPTY;
                end
            end
        end
    end

endmodule
`default_nettype wire

[design/mqm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox port checker
// Checks both handshakes, result consistency, item spacing and reset state.
// ----------------------------------------------------------------------------
module mqm_checker
    import mqm_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire req_t s_req,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire rsp_t m_rsp
);

    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_req))
        else $error("Input item changed while waiting.");

    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("Result item changed while stalled.");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.status != ST_OK |-> m_rsp.read_data == 16'd0
        && m_rsp.wake_mask == 8'd0)
        else $error("Failed command returned data or a wake mask.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while an item is in flight.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

endmodule

bind multi_queue_mailbox_with_wait_masks_top mqm_checker u_mqm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue mailbox testbench
// Drives init, send, receive, resume and invalid commands into the mailbox
// through a driver fed from a queue of pending items, predicts every result
// with a local model of the queues and their wait masks, and checks each
// result field by field as the monitor accepts it. Both sides idle at random,
// and the receiver holds off once for a long stretch so that the block stalls.
// ----------------------------------------------------------------------------
module tb;
    import mqm_pkg::*;

    localparam int ITEMS        = 1950;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 400;

    logic aclk;
    logic aresetn  = 1'b0;
    logic s_valid  = 1'b0;
    logic s_ready;
    req_t s_req    = '0;
    logic m_valid;
    logic m_ready  = 1'b0;
    rsp_t m_rsp;
    logic hold_off = 1'b0;

    req_t command_queue[$];
    rsp_t mailbox_replies[$];
    rsp_t want_rsp;

    int items_sent  = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int send_gap    = 0;
    int recv_gap    = 0;
    bit send_calm   = 1'b0;
    bit recv_calm   = 1'b0;

    logic [PTR_W-1:0] q_head    [QUEUES];
    logic [PTR_W-1:0] q_tail    [QUEUES];
    logic [CNT_W-1:0] q_ring    [QUEUES];
    logic [7:0]       q_allowed [QUEUES];
    logic [15:0]      q_waiting [QUEUES];
    logic [15:0]      q_words   [QUEUES][RING];
    logic [7:0]       gen_allowed [QUEUES];

    multi_queue_mailbox_with_wait_masks_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int next_slot(int ptr, int ring_size);
        int n;
        n = ptr + 1;
        if (n >= ring_size || n >= RING) begin
            return 0;
        end
        return n;
    endfunction

    function automatic rsp_t mailbox_step(req_t r);
        rsp_t       res;
        int         q;
        int         t;
        int         nxt;
        logic [7:0] acc;
        logic [15:0] sbit;
        logic [15:0] rbit;
        bit         sending;
        bit         resume;
        res        = '0;
        res.status = ST_INVALID;
        q          = int'(r.queue_id);
        t          = int'(r.task_id);
        acc        = r.access_mask & TASK_ALL;
        if (r.command == CMD_INIT) begin
            if (q < QUEUES && r.queue_length != 0 && r.queue_length <= DEPTH && acc != 0) begin
                q_ring[q]    = CNT_W'(r.queue_length) + CNT_W'(1);
                q_allowed[q] = acc;
                q_head[q]    = '0;
                q_tail[q]    = '0;
                q_waiting[q] = '0;
                res.status   = ST_OK;
            end
        end else if (r.command <= CMD_RESUME_RECV && q < QUEUES && t < TASKS
                     && q_allowed[q][t] == 1'b1) begin
            sbit    = 16'(1) << (t + 8);
            rbit    = 16'(1) << t;
            sending = (r.command == CMD_SEND || r.command == CMD_RESUME_SEND);
            resume  = (r.command == CMD_RESUME_SEND || r.command == CMD_RESUME_RECV);
            if (resume) begin
                q_waiting[q] &= ~(sending ? sbit : rbit);
            end
            if (sending) begin
                nxt = next_slot(int'(q_tail[q]), int'(q_ring[q]));
                if (nxt != int'(q_head[q])) begin
                    q_words[q][q_tail[q]] = r.send_value;
                    q_tail[q]     = PTR_W'(nxt);
                    res.status    = ST_OK;
                    res.wake_mask = q_waiting[q][7:0];
                end else if (!resume && r.may_wait) begin
                    q_waiting[q] |= sbit;
                    res.status = ST_BLOCKED;
                end else begin
                    res.status = ST_FULL;
                end
            end else begin
                if (q_head[q] != q_tail[q]) begin
                    res.read_data = q_words[q][q_head[q]];
                    q_head[q]     = PTR_W'(next_slot(int'(q_head[q]), int'(q_ring[q])));
                    res.status    = ST_OK;
                    res.wake_mask = q_waiting[q][15:8];
                end else if (!resume && r.may_wait) begin
                    q_waiting[q] |= rbit;
                    res.status = ST_BLOCKED;
                end else begin
                    res.status = ST_EMPTY;
                end
            end
        end
        return res;
    endfunction

    function automatic void push_item(logic [2:0] cmd, logic [2:0] qid, logic [2:0] tid,
                                      logic [15:0] value, logic w, logic [4:0] len,
                                      logic [7:0] mask);
        req_t r;
        r.command      = cmd;
        r.queue_id     = qid;
        r.task_id      = tid;
        r.send_value   = value;
        r.may_wait     = w;
        r.queue_length = len;
        r.access_mask  = mask;
        command_queue.push_back(r);
    endfunction

    function automatic logic [2:0] pick_task(logic [7:0] mask);
        logic [2:0] t;
        t = 3'($urandom_range(0, TASKS - 1));
        if ((mask & TASK_ALL) != 0 && $urandom_range(0, 9) != 0) begin
            while (mask[t] == 1'b0) begin
                t = 3'($urandom_range(0, TASKS - 1));
            end
        end
        return t;
    endfunction

    function automatic int pick_gap(inout bit calm);
        int r;
        if ($urandom_range(0, 149) == 0) begin
            calm = !calm;
        end
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                mailbox_replies.push_back(mailbox_step(s_req));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && command_queue.size() != 0) begin
                    s_req   <= command_queue.pop_front();
                    s_valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) begin
                        send_gap--;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mailbox_replies.size() == 0) begin
                    $error("result with none expected: status %0d, read_data %0h",
                           m_rsp.status, m_rsp.read_data);
                    err_count++;
                end else begin
                    want_rsp = mailbox_replies.pop_front();
                    if (m_rsp.status !== want_rsp.status) begin
                        $error("status: expected %0d, got %0d", want_rsp.status, m_rsp.status);
                        err_count++;
                    end
                    if (m_rsp.read_data !== want_rsp.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               want_rsp.read_data, m_rsp.read_data);
                        err_count++;
                    end
                    if (m_rsp.wake_mask !== want_rsp.wake_mask) begin
                        $error("wake_mask: expected %0h, got %0h",
                               want_rsp.wake_mask, m_rsp.wake_mask);
                        err_count++;
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = pick_gap(recv_calm);
            end
        end
    end

    initial begin
        while (items_sent < HOLD_AFTER) begin
            @(posedge aclk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        int         roll;
        int         fill_bias;
        logic [2:0] qid;
        logic [2:0] cmd;
        logic [4:0] len;
        logic [7:0] mask;
        bit         is_send;

        for (int q = 0; q < QUEUES; q++) begin
            q_head[q]      = '0;
            q_tail[q]      = '0;
            q_ring[q]      = '0;
            q_allowed[q]   = '0;
            q_waiting[q]   = '0;
            gen_allowed[q] = '0;
            for (int s = 0; s < RING; s++) begin
                q_words[q][s] = '0;
            end
        end

        push_item(CMD_SEND, 0, 0, 16'h1234, 1'b1, 5'd1, 8'hFF);
        for (int c = CMD_RESUME_RECV + 1; c < 8; c++) begin
            push_item(3'(c), 0, 0, 16'h0, 1'b0, 5'd1, 8'hFF);
        end
        push_item(CMD_INIT, 4, 0, 16'h0, 1'b0, 5'd1, 8'hFF);
        push_item(CMD_INIT, 7, 7, 16'h0, 1'b1, 5'd4, 8'hFF);
        push_item(CMD_INIT, 0, 0, 16'h0, 1'b0, 5'd0, 8'hFF);
        push_item(CMD_INIT, 0, 0, 16'h0, 1'b0, 5'd16, 8'hFF);
        push_item(CMD_INIT, 0, 0, 16'h0, 1'b0, 5'd31, 8'hFF);
        push_item(CMD_INIT, 0, 0, 16'h0, 1'b0, 5'd2, 8'h00);
        push_item(CMD_INIT, 0, 0, 16'h0, 1'b0, 5'd1, 8'h01);
        push_item(CMD_INIT, 1, 0, 16'h0, 1'b0, 5'd15, 8'hFF);
        push_item(CMD_INIT, 2, 0, 16'h0, 1'b0, 5'd3, 8'h80);
        gen_allowed[0] = 8'h01;
        gen_allowed[1] = 8'hFF;
        gen_allowed[2] = 8'h80;
        push_item(CMD_SEND, 0, 1, 16'hAAAA, 1'b0, 5'd0, 8'h0);
        push_item(CMD_SEND, 0, 0, 16'hFFFF, 1'b0, 5'd0, 8'h0);
        push_item(CMD_SEND, 0, 0, 16'h0001, 1'b0, 5'd0, 8'h0);
        push_item(CMD_SEND, 0, 0, 16'h0002, 1'b1, 5'd0, 8'h0);
        push_item(CMD_RECEIVE, 0, 0, 16'h0, 1'b0, 5'd0, 8'h0);
        push_item(CMD_RESUME_SEND, 0, 0, 16'h0000, 1'b0, 5'd0, 8'h0);
        push_item(CMD_RECEIVE, 0, 0, 16'h0, 1'b0, 5'd0, 8'h0);
        push_item(CMD_RECEIVE, 0, 0, 16'h0, 1'b0, 5'd0, 8'h0);
        push_item(CMD_RECEIVE, 0, 0, 16'h0, 1'b1, 5'd0, 8'h0);
        push_item(CMD_RESUME_RECV, 0, 0, 16'h0, 1'b1, 5'd0, 8'h0);
        push_item(CMD_RECEIVE, 2, 7, 16'h0, 1'b1, 5'd0, 8'h0);
        push_item(CMD_SEND, 2, 7, 16'h5A5A, 1'b0, 5'd0, 8'h0);
        push_item(CMD_RESUME_RECV, 2, 7, 16'h0, 1'b0, 5'd0, 8'h0);

        fill_bias = 50;
        while (command_queue.size() < ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                fill_bias = $urandom_range(0, 100);
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                push_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)));
            end else if (roll < 12) begin
                qid  = 3'($urandom_range(0, QUEUES - 1));
                mask = 8'($urandom_range(1, 255));
                if ($urandom_range(0, 3) != 0) begin
                    len = 5'($urandom_range(1, 4));
                end else begin
                    len = 5'($urandom_range(1, DEPTH));
                end
                gen_allowed[qid] = mask;
                push_item(CMD_INIT, qid, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), len, mask);
            end else begin
                qid     = 3'($urandom_range(0, QUEUES - 1));
                is_send = ($urandom_range(0, 99) < fill_bias);
                if ($urandom_range(0, 3) == 0) begin
                    cmd = is_send ? CMD_RESUME_SEND : CMD_RESUME_RECV;
                end else begin
                    cmd = is_send ? CMD_SEND : CMD_RECEIVE;
                end
                push_item(cmd, qid, pick_task(gen_allowed[qid]), 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (command_queue.size() != 0 || s_valid || mailbox_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
design/mqm_pkg.sv
design/mqm_ctrl_store.sv
design/mqm_slot_store.sv
design/mqm_engine.sv
design/multi_queue_mailbox_with_wait_masks_top.sv
design/mqm_checker.sv
dv/tb.sv
